/* rtl/core/sdb_pkg.sv */
// Package: types and constants for the SD card SPI boot loader.
`timescale 1ns / 1ps
`default_nettype none
package sdb_pkg;
    localparam int BLOCK_SIZE_BYTES = 512;
    localparam int DUMMY_CLOCK_BYTES = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [2:0] REG_IMAGE_MAGIC  = 3'd0;
    localparam logic [2:0] REG_MAX_BYTES    = 3'd1;
    localparam logic [2:0] REG_LOAD_BASE    = 3'd2;
    localparam logic [2:0] REG_RESP_LIMIT   = 3'd3;
    localparam logic [2:0] REG_TOKEN_LIMIT  = 3'd4;
    localparam logic [2:0] REG_RETRY_LIMIT  = 3'd5;
    localparam logic [2:0] REG_SLOW_DIV     = 3'd6;
    localparam logic [2:0] REG_FAST_DIV     = 3'd7;

    localparam logic [1:0] FAIL_CARD   = 2'd0;
    localparam logic [1:0] FAIL_HEADER = 2'd1;
    localparam logic [1:0] FAIL_SUM    = 2'd2;

    localparam logic [7:0] CMD0_CRC   = 8'h95;
    localparam logic [7:0] CMD8_CRC   = 8'h87;
    localparam logic [7:0] OTHER_CRC  = 8'h01;
    localparam logic [31:0] CMD8_ARG  = 32'h0000_01aa;
    localparam logic [31:0] ACMD41_ARG = 32'h4000_0000;
    localparam logic [7:0] START_TOKEN = 8'hfe;
    localparam logic [7:0] R7_CHECK   = 8'haa;
    localparam logic [7:0] IDLE_BYTE  = 8'hff;

    typedef enum logic [4:0] {
        PH_IDLE, PH_DUMMY,
        PH_C0_SEND, PH_C0_RESP, PH_C0_REL,
        PH_C8_SEND, PH_C8_RESP, PH_C8_R7, PH_C8_REL,
        PH_C55_SEND, PH_C55_RESP, PH_C55_REL,
        PH_C41_SEND, PH_C41_RESP, PH_C41_REL,
        PH_C17_SEND, PH_C17_RESP, PH_TOKEN, PH_DATA, PH_CRC, PH_C17_REL,
        PH_DONE, PH_FAIL_CARD, PH_FAIL_HEADER, PH_FAIL_SUM
    } t_phase;

    typedef struct packed {
        logic       command;
        logic [7:0] miso_byte;
    } t_in_item;

    typedef struct packed {
        logic        spi_request;
        logic [7:0]  mosi_byte;
        logic        card_select;
        logic [7:0]  spi_divider;
        logic        mem_write;
        logic [31:0] mem_address;
        logic [31:0] mem_word;
        logic        finished;
        logic        failed;
        logic [1:0]  fail_code;
        logic [31:0] entry_address;
    } t_out_item;

    function automatic logic [7:0] frame_byte(input logic [9:0] idx, input logic [5:0] cmd,
                                              input logic [31:0] arg, input logic [7:0] crc);
        logic [7:0] b;
        case (idx)
            10'd0: b = {2'b01, cmd};
            10'd1: b = arg[31:24];
            10'd2: b = arg[23:16];
            10'd3: b = arg[15:8];
            10'd4: b = arg[7:0];
            10'd5: b = crc;
            default: b = IDLE_BYTE;
        endcase
        return b;
    endfunction
endpackage
`default_nettype wire

/* rtl/core/sd_spi_image_boot_loader.sv */
// Top level: SD card SPI-mode init, header and image block reader.
`timescale 1ns / 1ps
`default_nettype none
// Each accepted item is a start command or the byte returned by the last SPI
// exchange; the block answers with one result item naming the next exchange,
// an optional memory word write, and the done/failed status. An item goes
// from the input register through one level of sequencing logic into the
// output register, so one item is taken per cycle while the output side
// keeps up; the result register and input register form the only pipeline.
module sd_spi_image_boot_loader #(
    parameter int DUMMY_BYTES = sdb_pkg::DUMMY_CLOCK_BYTES
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire sdb_pkg::t_in_item               i_item,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output sdb_pkg::t_out_item                   o_item,
    input  wire logic                            i_cfg_we,
    input  wire logic [sdb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [sdb_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import sdb_pkg::*;

    logic [31:0] r_magic, r_load_base;
    logic [28:0] r_max_bytes;
    logic [7:0]  r_resp_limit, r_slow_div, r_fast_div;
    logic [11:0] r_token_limit, r_retry_limit;

    t_phase      r_phase, n_phase;
    logic [9:0]  r_bcnt, n_bcnt;
    logic [11:0] r_att, n_att;
    logic [7:0]  r_resp, n_resp, r_chk, n_chk;
    logic [31:0] r_shift, n_shift, r_len, n_len, r_exp, n_exp, r_sum, n_sum;
    logic [26:0] r_wtot, n_wtot, r_wseen, n_wseen;
    logic [19:0] r_blk, n_blk, r_btot, n_btot;

    logic        r_in_valid;
    t_in_item    r_in;
    t_out_item   n_out;
    logic        adv;

    assign adv = r_in_valid && !(o_valid && i_stall);
    assign o_stall = r_in_valid && o_valid && i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= 32'h4353_5246;
            r_max_bytes <= 29'h1000_0000;
            r_load_base <= 32'h8000_0000;
            r_resp_limit <= 8'd32;
            r_token_limit <= 12'd1024;
            r_retry_limit <= 12'd1024;
            r_slow_div <= 8'd63;
            r_fast_div <= 8'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_IMAGE_MAGIC: r_magic <= i_cfg_data;
                REG_MAX_BYTES:   r_max_bytes <= i_cfg_data[28:0];
                REG_LOAD_BASE:   r_load_base <= i_cfg_data;
                REG_RESP_LIMIT:  r_resp_limit <= i_cfg_data[7:0];
                REG_TOKEN_LIMIT: r_token_limit <= i_cfg_data[11:0];
                REG_RETRY_LIMIT: r_retry_limit <= i_cfg_data[11:0];
                REG_SLOW_DIV:    r_slow_div <= i_cfg_data[7:0];
                REG_FAST_DIV:    r_fast_div <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            o_valid <= 1'b0;
            r_phase <= PH_IDLE;
            r_bcnt <= '0; r_att <= '0; r_resp <= '0; r_chk <= '0;
            r_shift <= '0; r_len <= '0; r_exp <= '0; r_sum <= '0;
            r_wtot <= '0; r_wseen <= '0; r_blk <= '0; r_btot <= '0;
        end else begin
            if (!o_stall) begin
                r_in_valid <= i_valid;
                r_in <= i_item;
            end
            if (adv) begin
                o_valid <= 1'b1;
                o_item <= n_out;
                r_phase <= n_phase;
                r_bcnt <= n_bcnt; r_att <= n_att; r_resp <= n_resp; r_chk <= n_chk;
                r_shift <= n_shift; r_len <= n_len; r_exp <= n_exp; r_sum <= n_sum;
                r_wtot <= n_wtot; r_wseen <= n_wseen; r_blk <= n_blk; r_btot <= n_btot;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
        end
    end

    logic [7:0]  b;
    logic [31:0] shifted;
    logic [7:0]  resp_lim;
    logic [11:0] tok_lim, ret_lim, att_inc;
    logic [9:0]  bc_inc;
    logic [28:0] len_up;
    logic [31:0] mosi_arg;

    always_comb begin
        b = r_in.miso_byte;
        n_phase = r_phase; n_bcnt = r_bcnt; n_att = r_att; n_resp = r_resp;
        n_chk = r_chk; n_shift = r_shift; n_len = r_len; n_exp = r_exp;
        n_sum = r_sum; n_wtot = r_wtot; n_wseen = r_wseen; n_blk = r_blk;
        n_btot = r_btot;
        n_out = '0;
        resp_lim = r_resp_limit;
        tok_lim = r_token_limit;
        ret_lim = r_retry_limit;
        bc_inc = r_bcnt + 10'd1;
        att_inc = r_att + 12'd1;
        shifted = {b, r_shift[31:8]};
        len_up = '0;
        mosi_arg = '0;
        if (!r_in.command) begin
            n_phase = PH_DUMMY; n_bcnt = '0; n_att = '0; n_resp = '0; n_chk = '0;
            n_shift = '0; n_len = '0; n_exp = '0; n_sum = '0; n_wtot = '0;
            n_wseen = '0; n_blk = '0; n_btot = '0;
        end else begin
            unique case (r_phase)
                PH_DUMMY: begin
                    n_bcnt = bc_inc;
                    if (bc_inc >= 10'(DUMMY_BYTES)) begin
                        n_phase = PH_C0_SEND; n_bcnt = '0;
                    end
                end
                PH_C0_SEND, PH_C8_SEND, PH_C55_SEND, PH_C41_SEND, PH_C17_SEND: begin
                    n_bcnt = bc_inc;
                    if (bc_inc >= 10'd8) begin
                        n_bcnt = '0;
                        n_phase = t_phase'(r_phase + 5'd1);
                    end
                end
                PH_C0_RESP, PH_C8_RESP, PH_C55_RESP, PH_C41_RESP, PH_C17_RESP: begin
                    if (b == IDLE_BYTE) begin
                        n_bcnt = bc_inc;
                        if (bc_inc >= {2'b00, resp_lim}) n_phase = PH_FAIL_CARD;
                    end else begin
                        n_resp = b; n_bcnt = '0;
                        if (r_phase != PH_C17_RESP) n_phase = t_phase'(r_phase + 5'd1);
                        else if (b != 8'd0) n_phase = PH_FAIL_CARD;
                        else begin
                            n_phase = PH_TOKEN; n_att = '0;
                        end
                    end
                end
                PH_C0_REL: begin
                    if (r_resp != 8'd1) n_phase = PH_FAIL_CARD;
                    else begin
                        n_phase = PH_C8_SEND; n_bcnt = '0;
                    end
                end
                PH_C8_R7: begin
                    n_chk = b; n_bcnt = bc_inc;
                    if (bc_inc >= 10'd4) begin
                        n_phase = PH_C8_REL; n_bcnt = '0;
                    end
                end
                PH_C8_REL: begin
                    if (r_resp != 8'd1 || r_chk != R7_CHECK) n_phase = PH_FAIL_CARD;
                    else begin
                        n_att = '0; n_phase = PH_C55_SEND; n_bcnt = '0;
                    end
                end
                PH_C55_REL: begin
                    n_phase = PH_C41_SEND; n_bcnt = '0;
                end
                PH_C41_REL: begin
                    if (r_resp == 8'd0) begin
                        n_blk = '0; n_wseen = '0; n_sum = '0;
                        n_phase = PH_C17_SEND; n_bcnt = '0;
                    end else if (r_resp != 8'd1) n_phase = PH_FAIL_CARD;
                    else begin
                        n_att = att_inc;
                        if (att_inc >= ret_lim || att_inc == 12'd0) n_phase = PH_FAIL_CARD;
                        else begin
                            n_phase = PH_C55_SEND; n_bcnt = '0;
                        end
                    end
                end
                PH_TOKEN: begin
                    if (b == START_TOKEN) begin
                        n_phase = PH_DATA; n_bcnt = '0; n_shift = '0;
                    end else if (b != IDLE_BYTE) n_phase = PH_FAIL_CARD;
                    else begin
                        n_att = att_inc;
                        if (att_inc >= tok_lim || att_inc == 12'd0) n_phase = PH_FAIL_CARD;
                    end
                end
                PH_DATA: begin
                    n_shift = shifted; n_bcnt = bc_inc;
                    if (bc_inc[1:0] == 2'd0) begin
                        if (r_blk == 20'd0) begin
                            if (r_bcnt[9:2] == 8'd0) n_sum = shifted;
                            else if (r_bcnt[9:2] == 8'd1) n_len = shifted;
                            else if (r_bcnt[9:2] == 8'd2) n_exp = shifted;
                        end else begin
                            n_out.mem_write = 1'b1;
                            n_out.mem_address = r_load_base + {3'b000, r_wseen, 2'b00};
                            n_out.mem_word = shifted;
                            if (r_wseen < r_wtot) n_sum = r_sum + shifted;
                            n_wseen = r_wseen + 27'd1;
                        end
                    end
                    if (r_bcnt == 10'(BLOCK_SIZE_BYTES - 1)) begin
                        n_phase = PH_CRC; n_bcnt = '0;
                    end
                end
                PH_CRC: begin
                    n_bcnt = bc_inc;
                    if (bc_inc >= 10'd2) begin
                        n_phase = PH_C17_REL; n_bcnt = '0;
                    end
                end
                PH_C17_REL: begin
                    if (r_blk == 20'd0) begin
                        if (r_sum != r_magic || r_len == 32'd0 ||
                            r_len >= {3'b000, r_max_bytes}) n_phase = PH_FAIL_HEADER;
                        else begin
                            len_up = r_len[28:0] + 29'd3;
                            n_wtot = len_up[28:2];
                            n_btot = 20'(({1'b0, len_up[28:2]} + 28'd127) >> 7);
                            n_sum = '0; n_wseen = '0; n_blk = 20'd1;
                            n_phase = PH_C17_SEND; n_bcnt = '0;
                        end
                    end else if (r_blk >= r_btot) begin
                        n_phase = (r_sum == r_exp) ? PH_DONE : PH_FAIL_SUM;
                    end else begin
                        n_blk = r_blk + 20'd1;
                        n_phase = PH_C17_SEND; n_bcnt = '0;
                    end
                end
                default: ;
            endcase
        end

        mosi_arg = {12'd0, n_blk};
        n_out.spi_request = 1'b1;
        n_out.mosi_byte = IDLE_BYTE;
        n_out.card_select = 1'b1;
        unique case (n_phase)
            PH_DUMMY, PH_C0_REL, PH_C8_REL, PH_C55_REL, PH_C41_REL, PH_C17_REL:
                n_out.card_select = 1'b0;
            PH_C0_SEND:  n_out.mosi_byte = frame_byte(n_bcnt, 6'd0, 32'd0, CMD0_CRC);
            PH_C8_SEND:  n_out.mosi_byte = frame_byte(n_bcnt, 6'd8, CMD8_ARG, CMD8_CRC);
            PH_C55_SEND: n_out.mosi_byte = frame_byte(n_bcnt, 6'd55, 32'd0, OTHER_CRC);
            PH_C41_SEND: n_out.mosi_byte = frame_byte(n_bcnt, 6'd41, ACMD41_ARG, OTHER_CRC);
            PH_C17_SEND: n_out.mosi_byte = frame_byte(n_bcnt, 6'd17, mosi_arg, OTHER_CRC);
            PH_IDLE: n_out.spi_request = 1'b0;
            PH_DONE: begin
                n_out.spi_request = 1'b0;
                n_out.finished = 1'b1;
                n_out.entry_address = r_load_base + {3'b000, n_wtot, 2'b00};
            end
            PH_FAIL_CARD: begin
                n_out.spi_request = 1'b0; n_out.failed = 1'b1; n_out.fail_code = FAIL_CARD;
            end
            PH_FAIL_HEADER: begin
                n_out.spi_request = 1'b0; n_out.failed = 1'b1;
                n_out.fail_code = FAIL_HEADER;
            end
            PH_FAIL_SUM: begin
                n_out.spi_request = 1'b0; n_out.failed = 1'b1; n_out.fail_code = FAIL_SUM;
            end
            default: ;
        endcase
        if (n_out.spi_request) begin
            n_out.spi_divider = (n_phase >= PH_C17_SEND) ? r_fast_div : r_slow_div;
        end else begin
            n_out.mosi_byte = '0;
            n_out.card_select = 1'b0;
        end
    end
endmodule
`default_nettype wire

/* bench/tb_sd_spi_image_boot_loader.sv */
// Testbench: SD card SPI boot loader driven by a card emulator, checked by a scoreboard.
`timescale 1ns / 1ps
module tb_sd_spi_image_boot_loader;
    import sdb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_ITEMS = 40;

    class boot_scoreboard;
        t_out_item   pending_q[$];
        int          errors;
        t_phase      ph;
        bit [9:0]    bc;
        bit [11:0]   att;
        bit [7:0]    resp, chk;
        bit [31:0]   ws, ilen, esum, rsum;
        bit [26:0]   wtot, wseen;
        bit [19:0]   blk, btot;
        bit [31:0]   magic, base;
        bit [28:0]   maxb;
        bit [7:0]    rlim, sdiv, fdiv;
        bit [11:0]   tlim, rtlim;

        function new();
            errors = 0;
            magic = 32'h4353_5246; maxb = 29'h1000_0000; base = 32'h8000_0000;
            rlim = 8'd32; tlim = 12'd1024; rtlim = 12'd1024; sdiv = 8'd63; fdiv = 8'd1;
            clear();
        endfunction

        function void clear();
            ph = PH_IDLE; bc = '0; att = '0; resp = '0; chk = '0; ws = '0; ilen = '0;
            esum = '0; rsum = '0; wtot = '0; wseen = '0; blk = '0; btot = '0;
        endfunction

        function void set_reg(bit [2:0] idx, bit [31:0] v);
            case (idx)
                REG_IMAGE_MAGIC: magic = v;
                REG_MAX_BYTES:   maxb = v[28:0];
                REG_LOAD_BASE:   base = v;
                REG_RESP_LIMIT:  rlim = v[7:0];
                REG_TOKEN_LIMIT: tlim = v[11:0];
                REG_RETRY_LIMIT: rtlim = v[11:0];
                REG_SLOW_DIV:    sdiv = v[7:0];
                REG_FAST_DIV:    fdiv = v[7:0];
                default: ;
            endcase
        endfunction

        function bit [7:0] cmd_frame_byte(bit [5:0] cmd, bit [31:0] arg, bit [7:0] crc);
            case (bc)
                10'd0: return {2'b01, cmd};
                10'd1: return arg[31:24];
                10'd2: return arg[23:16];
                10'd3: return arg[15:8];
                10'd4: return arg[7:0];
                10'd5: return crc;
                default: return 8'hff;
            endcase
        endfunction

        function void send_step(t_phase nxt);
            bc++;
            if (bc >= 8) begin
                ph = nxt;
                bc = '0;
            end
        endfunction

        function void block_done();
            bit [31:0] t;
            if (blk == 0) begin
                if (rsum != magic || ilen == 0 || ilen >= {3'b0, maxb}) begin
                    ph = PH_FAIL_HEADER;
                    return;
                end
                t = ilen + 32'd3;
                wtot = t[28:2];
                t = ({5'b0, wtot} + 32'd127) / 32'd128;
                btot = t[19:0];
                rsum = '0; wseen = '0; blk = 20'd1; ph = PH_C17_SEND; bc = '0;
                return;
            end
            if (blk >= btot) begin
                ph = (rsum == esum) ? PH_DONE : PH_FAIL_SUM;
                return;
            end
            blk++;
            ph = PH_C17_SEND;
            bc = '0;
        endfunction

        function void advance(bit [7:0] b, inout t_out_item o);
            bit [7:0] idx;
            case (ph)
                PH_DUMMY: begin
                    bc++;
                    if (bc >= DUMMY_CLOCK_BYTES) begin
                        ph = PH_C0_SEND;
                        bc = '0;
                    end
                end
                PH_C0_SEND:  send_step(PH_C0_RESP);
                PH_C8_SEND:  send_step(PH_C8_RESP);
                PH_C55_SEND: send_step(PH_C55_RESP);
                PH_C41_SEND: send_step(PH_C41_RESP);
                PH_C17_SEND: send_step(PH_C17_RESP);
                PH_C0_RESP, PH_C8_RESP, PH_C55_RESP, PH_C41_RESP, PH_C17_RESP: begin
                    if (b == 8'hff) begin
                        bc++;
                        if (bc >= rlim) ph = PH_FAIL_CARD;
                    end else begin
                        resp = b;
                        bc = '0;
                        case (ph)
                            PH_C0_RESP:  ph = PH_C0_REL;
                            PH_C8_RESP:  ph = PH_C8_R7;
                            PH_C55_RESP: ph = PH_C55_REL;
                            PH_C41_RESP: ph = PH_C41_REL;
                            default: begin
                                if (b != 0) ph = PH_FAIL_CARD;
                                else begin
                                    ph = PH_TOKEN;
                                    att = '0;
                                end
                            end
                        endcase
                    end
                end
                PH_C0_REL: begin
                    if (resp != 1) ph = PH_FAIL_CARD;
                    else begin
                        ph = PH_C8_SEND;
                        bc = '0;
                    end
                end
                PH_C8_R7: begin
                    chk = b;
                    bc++;
                    if (bc >= 4) begin
                        ph = PH_C8_REL;
                        bc = '0;
                    end
                end
                PH_C8_REL: begin
                    if (resp != 1 || chk != R7_CHECK) ph = PH_FAIL_CARD;
                    else begin
                        att = '0;
                        ph = PH_C55_SEND;
                        bc = '0;
                    end
                end
                PH_C55_REL: begin
                    ph = PH_C41_SEND;
                    bc = '0;
                end
                PH_C41_REL: begin
                    if (resp == 0) begin
                        blk = '0; wseen = '0; rsum = '0; ph = PH_C17_SEND; bc = '0;
                    end else if (resp != 1) ph = PH_FAIL_CARD;
                    else begin
                        att++;
                        if (att >= rtlim || att == 0) ph = PH_FAIL_CARD;
                        else begin
                            ph = PH_C55_SEND;
                            bc = '0;
                        end
                    end
                end
                PH_TOKEN: begin
                    if (b == START_TOKEN) begin
                        ph = PH_DATA; bc = '0; ws = '0;
                    end else if (b != 8'hff) ph = PH_FAIL_CARD;
                    else begin
                        att++;
                        if (att >= tlim || att == 0) ph = PH_FAIL_CARD;
                    end
                end
                PH_DATA: begin
                    ws = {b, ws[31:8]};
                    bc++;
                    if (bc[1:0] == 2'b00) begin
                        idx = 8'(bc[9:2] - 8'd1);
                        if (blk == 0) begin
                            if (idx == 0) rsum = ws;
                            else if (idx == 1) ilen = ws;
                            else if (idx == 2) esum = ws;
                        end else begin
                            o.mem_write = 1'b1;
                            o.mem_address = base + {3'b0, wseen, 2'b00};
                            o.mem_word = ws;
                            if (wseen < wtot) rsum += ws;
                            wseen++;
                        end
                    end
                    if (bc >= BLOCK_SIZE_BYTES) begin
                        ph = PH_CRC;
                        bc = '0;
                    end
                end
                PH_CRC: begin
                    bc++;
                    if (bc >= 2) begin
                        ph = PH_C17_REL;
                        bc = '0;
                    end
                end
                PH_C17_REL: block_done();
                default: ;
            endcase
        endfunction

        function t_out_item predict_result(t_in_item it);
            t_out_item o;
            bit req, cs;
            bit [7:0] mosi;
            o = '0;
            if (!it.command) begin
                clear();
                ph = PH_DUMMY;
            end else advance(it.miso_byte, o);
            req = 1'b1; cs = 1'b1; mosi = 8'hff;
            case (ph)
                PH_DUMMY, PH_C0_REL, PH_C8_REL, PH_C55_REL, PH_C41_REL, PH_C17_REL: cs = 1'b0;
                PH_C0_SEND:  mosi = cmd_frame_byte(6'd0, 32'd0, CMD0_CRC);
                PH_C8_SEND:  mosi = cmd_frame_byte(6'd8, CMD8_ARG, CMD8_CRC);
                PH_C55_SEND: mosi = cmd_frame_byte(6'd55, 32'd0, OTHER_CRC);
                PH_C41_SEND: mosi = cmd_frame_byte(6'd41, ACMD41_ARG, OTHER_CRC);
                PH_C17_SEND: mosi = cmd_frame_byte(6'd17, {12'b0, blk}, OTHER_CRC);
                PH_IDLE: req = 1'b0;
                PH_DONE: begin
                    req = 1'b0;
                    o.finished = 1'b1;
                    o.entry_address = base + {3'b0, wtot, 2'b00};
                end
                PH_FAIL_CARD: begin
                    req = 1'b0; o.failed = 1'b1; o.fail_code = FAIL_CARD;
                end
                PH_FAIL_HEADER: begin
                    req = 1'b0; o.failed = 1'b1; o.fail_code = FAIL_HEADER;
                end
                PH_FAIL_SUM: begin
                    req = 1'b0; o.failed = 1'b1; o.fail_code = FAIL_SUM;
                end
                default: ;
            endcase
            if (req) begin
                o.spi_request = 1'b1;
                o.mosi_byte = mosi;
                o.card_select = cs;
                o.spi_divider = (ph >= PH_C17_SEND) ? fdiv : sdiv;
            end
            return o;
        endfunction

        function void note_item(t_in_item it);
            pending_q.push_back(predict_result(it));
        endfunction

        function void cmp(string name, longint unsigned e, longint unsigned a);
            if (e != a) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item e;
            if (pending_q.size() == 0) begin
                $error("result item with nothing expected");
                errors++;
                return;
            end
            e = pending_q.pop_front();
            cmp("spi_request", e.spi_request, got.spi_request);
            cmp("mosi_byte", e.mosi_byte, got.mosi_byte);
            cmp("card_select", e.card_select, got.card_select);
            cmp("spi_divider", e.spi_divider, got.spi_divider);
            cmp("mem_write", e.mem_write, got.mem_write);
            cmp("mem_address", e.mem_address, got.mem_address);
            cmp("mem_word", e.mem_word, got.mem_word);
            cmp("finished", e.finished, got.finished);
            cmp("failed", e.failed, got.failed);
            cmp("fail_code", e.fail_code, got.fail_code);
            cmp("entry_address", e.entry_address, got.entry_address);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_in_item              i_item = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_out_item             o_item;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    boot_scoreboard sb = new();
    int gap_pct, stall_pct, idle_cycles, n_items, n_results, n_boots, n_done, n_fail;
    int n_cut;
    int err_rate, acmd_rounds, tok_polls;
    bit force_bad_r1;
    bit [31:0] hdr_magic, hdr_len, hdr_sum;
    bit [31:0] img [512];

    sd_spi_image_boot_loader u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_result(o_item);
                n_results++;
            end
            if ((o_valid && !i_stall) || (i_valid && !o_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_sd_spi_image_boot_loader NOT OK");
                $finish;
            end
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    task automatic send(bit cmd, bit [7:0] b);
        t_in_item it;
        it.command = cmd;
        it.miso_byte = b;
        while ($urandom_range(0, 99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_item(it);
        n_items++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_regs(bit [31:0] vals [8]);
        i_cfg_we <= 1'b1;
        for (int k = 0; k < 8; k++) begin
            i_cfg_index <= k[2:0];
            i_cfg_data <= vals[k];
            sb.set_reg(k[2:0], vals[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic void plan_boot();
        bit [31:0] total, cap;
        int nwords;
        err_rate = ($urandom_range(0, 3) == 0) ? 25 : 0;
        acmd_rounds = $urandom_range(0, 3);
        if (acmd_rounds > int'(sb.rtlim) - 1) acmd_rounds = int'(sb.rtlim) - 1;
        tok_polls = $urandom_range(0, 2);
        if (tok_polls > int'(sb.tlim) - 1) tok_polls = int'(sb.tlim) - 1;
        hdr_magic = ($urandom_range(0, 9) == 0) ? $urandom : sb.magic;
        cap = ({3'b0, sb.maxb} > 32'd1900) ? 32'd1900 : {3'b0, sb.maxb} - 32'd1;
        case ($urandom_range(0, 19))
            0: hdr_len = 32'd0;
            1: hdr_len = $urandom | 32'h8000_0000;
            2: hdr_len = {3'b0, sb.maxb};
            3: hdr_len = (cap >= 600) ? $urandom_range(600, cap) : cap;
            default: hdr_len = (cap >= 64) ? $urandom_range(1, 64) : cap;
        endcase
        if (hdr_len == 0 && cap == 0) hdr_len = {3'b0, sb.maxb};
        total = '0;
        nwords = (hdr_len < 2048) ? int'((hdr_len + 3) >> 2) : 0;
        for (int k = 0; k < 512; k++) begin
            img[k] = $urandom;
            if (k < nwords) total += img[k];
        end
        hdr_sum = total ^ (($urandom_range(0, 6) == 0) ? (32'd1 << $urandom_range(0, 31)) : 0);
    endfunction

    function automatic bit [7:0] card_byte();
        bit [31:0] w;
        int idx;
        if (err_rate != 0 && !(sb.ph == PH_DATA && sb.blk == 0) &&
            $urandom_range(0, 999) < err_rate) return 8'($urandom);
        case (sb.ph)
            PH_C0_RESP, PH_C8_RESP, PH_C55_RESP, PH_C41_RESP, PH_C17_RESP: begin
                if ($urandom_range(0, 3) == 0 && int'(sb.bc) + 1 < int'(sb.rlim))
                    return 8'hff;
                case (sb.ph)
                    PH_C0_RESP:  return force_bad_r1 ? 8'h05 : 8'h01;
                    PH_C41_RESP: return (int'(sb.att) < acmd_rounds) ? 8'h01 : 8'h00;
                    PH_C17_RESP: return 8'h00;
                    default:     return 8'h01;
                endcase
            end
            PH_C8_R7: return (sb.bc == 3) ? R7_CHECK : 8'($urandom);
            PH_TOKEN: return (int'(sb.att) < tok_polls) ? 8'hff : START_TOKEN;
            PH_DATA: begin
                idx = int'(sb.bc >> 2);
                if (sb.blk == 0) begin
                    case (idx)
                        0: w = hdr_magic;
                        1: w = hdr_len;
                        2: w = hdr_sum;
                        default: w = $urandom;
                    endcase
                end else w = img[((int'(sb.blk) - 1) * 128 + idx) & 511];
                return 8'(w >> (8 * sb.bc[1:0]));
            end
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic bit boot_over();
        return sb.ph inside {PH_DONE, PH_FAIL_CARD, PH_FAIL_HEADER, PH_FAIL_SUM};
    endfunction

    task automatic run_boot(bit hold_off, int stop_at);
        int restart_at, k;
        if (hold_off) drain();
        plan_boot();
        restart_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 300) : -1;
        k = 0;
        send(1'b0, 8'($urandom));
        while (!boot_over() && (stop_at < 0 || n_items < stop_at)) begin
            if (k == restart_at) send(1'b0, 8'($urandom));
            else send(1'b1, card_byte());
            k++;
        end
        n_boots++;
        if (!boot_over()) n_cut++;
        else if (sb.ph == PH_DONE) n_done++;
        else n_fail++;
        if (boot_over() && $urandom_range(0, 3) == 0) send(1'b1, 8'($urandom));
    endtask

    initial begin
        bit [31:0] regs [8];
        int phase_start;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int p = 0; p < 6; p++) begin
            gap_pct = (p < 2) ? 33 : (p < 4) ? 71 : 0;
            stall_pct = (p < 2) ? 71 : (p < 4) ? 33 : 0;
            drain();
            case (p)
                0: regs = '{32'h4353_5246, 32'h1000_0000, 32'h8000_0000, 32'd32,
                           32'd1024, 32'd1024, 32'd63, 32'd1};
                1: regs = '{32'hffff_ffff, 32'd1, 32'hffff_fff0, 32'd1,
                           32'd1, 32'd1, 32'd0, 32'd255};
                2: regs = '{32'h0, 32'd2000, 32'h0, 32'd255,
                           32'd4095, 32'd4095, 32'd255, 32'd0};
                5: regs = '{32'h4353_5246, 32'h1000_0000, 32'hffff_fffc, 32'd3,
                           32'd4, 32'd5, 32'd10, 32'd2};
                default: regs = '{$urandom,
                                  ($urandom_range(0, 1) != 0) ? $urandom_range(1, 4096)
                                                              : 32'h1000_0000,
                                  $urandom, $urandom_range(1, 255), $urandom_range(1, 4095),
                                  $urandom_range(1, 4095), $urandom_range(0, 255),
                                  $urandom_range(0, 255)};
            endcase
            write_regs(regs);
            if (p == 0) begin
                send(1'b1, 8'hff);
                send(1'b1, 8'h00);
                plan_boot();
                send(1'b0, 8'h00);
                repeat (12) send(1'b1, card_byte());
                force_bad_r1 = 1'b1;
                send(1'b0, 8'hff);
                while (!boot_over()) send(1'b1, card_byte());
                force_bad_r1 = 1'b0;
                send(1'b1, 8'h5a);
            end
            phase_start = n_items;
            while (n_items - phase_start < PHASE_ITEMS || (p == 5 && n_done == 0))
                run_boot(p == 3, (p == 5) ? -1 : phase_start + PHASE_ITEMS);
        end
        i_valid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("Ran %0d items through %0d boots (%0d loaded, %0d stopped with an error,",
                 n_items, n_boots, n_done, n_fail);
        $display("%0d cut short) over six register settings and three idling patterns.",
                 n_cut);
        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("tb_sd_spi_image_boot_loader OK");
        else
            $display("tb_sd_spi_image_boot_loader NOT OK");
        $finish;
    end
endmodule

/* sd_spi_image_boot_loader.f */
rtl/core/sdb_pkg.sv
rtl/core/sd_spi_image_boot_loader.sv
bench/tb_sd_spi_image_boot_loader.sv
